/* hw/rtl/navpf_pkg.sv */
// Package: shared constants, codes and state type for the position fusion block
`timescale 1ns / 1ps
`default_nettype none
package navpf_pkg;

  localparam int STATE_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int GAIN_W          = 16;
  localparam int DIV_W           = 12;

  localparam logic [DIV_W-1:0] DIV_IMU  = 12'd4000;
  localparam logic [DIV_W-1:0] DIV_POS  = 12'd3200;
  localparam logic [DIV_W-1:0] DIV_PULL = 12'd200;

  localparam logic [2:0] CMD_ACCEL  = 3'd0;
  localparam logic [2:0] CMD_BARO   = 3'd1;
  localparam logic [2:0] CMD_FLOW   = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_FLIGHT = 3'd4;
  localparam logic [2:0] CMD_MODE   = 3'd5;

  localparam logic [7:0] ALT_MODE_BARO = 8'd0;
  localparam logic [7:0] ALT_MODE_FLOW = 8'd1;

  localparam logic [2:0] REG_FLOW_SCALE    = 3'd0;
  localparam logic [2:0] REG_FLOW_VEL_GAIN = 3'd1;
  localparam logic [2:0] REG_FLOW_ALT_GAIN = 3'd2;
  localparam logic [2:0] REG_BARO_ALT_GAIN = 3'd3;
  localparam logic [2:0] REG_BARO_FAST     = 3'd4;
  localparam logic [2:0] REG_BARO_SLOW     = 3'd5;
  localparam logic [2:0] REG_ACCEL_THR     = 3'd6;
  localparam logic [2:0] REG_OUT_SCALE     = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_V,
    ST_ACC_P,
    ST_ACC_PULL,
    ST_BARO,
    ST_FLOW_S,
    ST_FLOW_V,
    ST_ALT_SET,
    ST_ALT_V,
    ST_TICK
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/nav_position_fusion.sv */
// Top level: three-axis position and velocity estimator with serial arithmetic
//
//  channel   dir  handshake              contents
//  s_axis    in   s_tvalid / s_tready    tuser cmd, tdata sensor fields
//  m_axis    out  m_tvalid / m_tready    tdata position, velocity, monitors
//  apb       in   psel/penable/pready    eight 16-bit gain and scale registers
//
//  One event at a time. Arithmetic runs on a bit-serial multiplier and a
//  bit-serial divider. Accel: 8 divisions (velocity on three axes, position
//  on X and Y, pull to the reference on three axes). Baro one multiply, flow
//  four, each plus one with an altitude update; tick three; flight state and
//  mode set on acceptance. A tick waits for m_axis to drain.
//  Synchronous reset clears the estimator state and control; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module nav_position_fusion #(
  parameter int STATE_WIDTH = navpf_pkg::STATE_WIDTH_DEF,
  parameter int FRAC_BITS   = navpf_pkg::FRAC_BITS_DEF,
  parameter int OUT_W       = ((6 * STATE_WIDTH + 64 + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // accel_x, accel_y, accel_z, flow_dx, flow_dy, flow_dist, baro_alt,
  // flight_state, alt_mode, zero pad
  input  wire logic [191:0]      s_tdata,
  // cmd
  input  wire logic [2:0]        s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, alt_rate_int, vert_vel_int, zero pad
  output logic [OUT_W-1:0]       m_tdata,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import navpf_pkg::*;

  localparam int W   = STATE_WIDTH;
  localparam int XW  = W + 26;
  localparam int DW  = W + FRAC_BITS;
  localparam int PW  = W + GAIN_W;
  localparam int SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [XW-1:0] HI_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] LO_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] I32_HI = XW'(64'sh7FFFFFFF);
  localparam logic signed [XW-1:0] I32_LO = -XW'(64'sh80000000);
  localparam logic signed [XW-1:0] RND = XW'((64'sd1 <<< FRAC_BITS) - 1);

  function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
    if (v > HI_X) return HI_X[W-1:0];
    if (v < LO_X) return LO_X[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat(XW'(a) + XW'(b));
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat(XW'(a) - XW'(b));
  endfunction

  function automatic logic signed [W-1:0] mul100(input logic signed [W-1:0] a);
    logic signed [XW-1:0] e;
    e = XW'(a);
    return sat((e <<< 6) + (e <<< 5) + (e <<< 2));
  endfunction

  function automatic logic [31:0] to_int32(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (v < 0) e = e + RND;
    e = e >>> FRAC_BITS;
    if (e > I32_HI) e = I32_HI;
    if (e < I32_LO) e = I32_LO;
    return e[31:0];
  endfunction

  // configuration
  logic [15:0] flow_scale, flow_vel_gain, flow_alt_vel_gain, baro_alt_vel_gain;
  logic [15:0] baro_fast_gain, baro_slow_gain, accel_threshold, output_scale;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_scale        <= 16'd655;
      flow_vel_gain     <= 16'd655;
      flow_alt_vel_gain <= 16'd655;
      baro_alt_vel_gain <= 16'd328;
      baro_fast_gain    <= 16'd3277;
      baro_slow_gain    <= 16'd328;
      accel_threshold   <= 16'd300;
      output_scale      <= 16'd13107;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FLOW_SCALE:    flow_scale        <= pwdata[15:0];
        REG_FLOW_VEL_GAIN: flow_vel_gain     <= pwdata[15:0];
        REG_FLOW_ALT_GAIN: flow_alt_vel_gain <= pwdata[15:0];
        REG_BARO_ALT_GAIN: baro_alt_vel_gain <= pwdata[15:0];
        REG_BARO_FAST:     baro_fast_gain    <= pwdata[15:0];
        REG_BARO_SLOW:     baro_slow_gain    <= pwdata[15:0];
        REG_ACCEL_THR:     accel_threshold   <= pwdata[15:0];
        REG_OUT_SCALE:     output_scale      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FLOW_SCALE:    prdata = 32'(flow_scale);
      REG_FLOW_VEL_GAIN: prdata = 32'(flow_vel_gain);
      REG_FLOW_ALT_GAIN: prdata = 32'(flow_alt_vel_gain);
      REG_BARO_ALT_GAIN: prdata = 32'(baro_alt_vel_gain);
      REG_BARO_FAST:     prdata = 32'(baro_fast_gain);
      REG_BARO_SLOW:     prdata = 32'(baro_slow_gain);
      REG_ACCEL_THR:     prdata = 32'(accel_threshold);
      REG_OUT_SCALE:     prdata = 32'(output_scale);
      default:           prdata = '0;
    endcase
  end

  // state
  logic signed [W-1:0] vel [3];
  logic signed [W-1:0] pos [3];
  logic signed [W-1:0] refp [3];
  logic signed [W-1:0] pbias [3];
  logic signed [W-1:0] vbias [3];
  logic signed [W-1:0] baro_filtered, alt_previous, alt_step;
  logic signed [15:0]  last_accel_z;
  logic [7:0]          mode_now, mode_seen;

  // captured event
  logic signed [15:0]  acc_in [3];
  logic signed [31:0]  flow_in [2];
  logic signed [31:0]  dist_in, baro_in;
  logic signed [W-1:0] alt_val, st_val;
  logic                alt_flow;

  state_t state, state_next;
  logic [1:0] ax;
  logic       run;
  logic       s_acc;

  logic                    mul_start, mul_done, mul_busy;
  logic signed [W-1:0]     mul_a;
  logic [GAIN_W-1:0]       mul_g;
  logic signed [PW-1:0]    mul_prod;
  logic                    div_start, div_done, div_busy;
  logic signed [DW-1:0]    div_x;
  logic [DIV_W-1:0]        div_d;
  logic signed [DW:0]      div_q;

  logic signed [W-1:0]  mulq, flow_st, baro_raw, flow_alt, div_w;
  logic signed [W-1:0]  alt_prev_sel, alt_step_new, bf_new, tick_p, tick_v;
  logic [16:0]          az_abs;
  logic [GAIN_W-1:0]    baro_gain;

  assign s_acc = s_tvalid && s_tready;

  navpf_mul_serial #(.AW(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .g(mul_g),
    .done(mul_done), .busy(mul_busy), .prod(mul_prod)
  );

  navpf_div_serial #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .x(div_x), .d(div_d),
    .done(div_done), .busy(div_busy), .q(div_q)
  );

  assign mulq     = sat(XW'(mul_prod) >>> 16);
  assign flow_st  = sat((XW'(mul_prod) <<< SHL) >>> SHR);
  assign baro_raw = sat((XW'(baro_in) <<< SHL) >>> SHR);
  assign flow_alt = sat(XW'(dist_in) <<< FRAC_BITS);
  assign div_w    = sat(XW'(div_q));
  assign az_abs   = last_accel_z[15] ? 17'(-17'(last_accel_z)) : 17'(last_accel_z);
  assign baro_gain = (az_abs > 17'(accel_threshold)) ? baro_fast_gain : baro_slow_gain;
  assign bf_new   = sadd(baro_filtered, mulq);
  assign alt_prev_sel = (mode_seen != (alt_flow ? ALT_MODE_FLOW : ALT_MODE_BARO)) ?
                        alt_val : alt_previous;
  assign alt_step_new = ssub(alt_val, alt_prev_sel);
  assign tick_p = (ax == 2'd2) ? mulq : sat(-XW'(mulq));
  assign tick_v = (ax == 2'd2) ? ssub(vel[ax], vbias[ax]) :
                  sat(-XW'(ssub(vel[ax], vbias[ax])));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          case (s_tuser)
            CMD_ACCEL: state_next = ST_ACC_V;
            CMD_BARO:  state_next = ST_BARO;
            CMD_FLOW:  state_next = ST_FLOW_S;
            CMD_TICK:  state_next = ST_TICK;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACC_V:    if (div_done && ax == 2'd2) state_next = ST_ACC_P;
      ST_ACC_P:    if (div_done && ax == 2'd1) state_next = ST_ACC_PULL;
      ST_ACC_PULL: if (div_done && ax == 2'd2) state_next = ST_IDLE;
      ST_BARO: begin
        if (mul_done) state_next = (mode_now == ALT_MODE_BARO) ? ST_ALT_SET : ST_IDLE;
      end
      ST_FLOW_S:   if (mul_done) state_next = ST_FLOW_V;
      ST_FLOW_V: begin
        if (mul_done) begin
          if (ax == 2'd1)
            state_next = (mode_now == ALT_MODE_FLOW) ? ST_ALT_SET : ST_IDLE;
          else
            state_next = ST_FLOW_S;
        end
      end
      ST_ALT_SET:  state_next = ST_ALT_V;
      ST_ALT_V:    if (mul_done) state_next = ST_IDLE;
      ST_TICK:     if (mul_done && ax == 2'd2) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    s_tready  = (state == ST_IDLE);
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_g     = '0;
    div_x     = '0;
    div_d     = DIV_IMU;
    case (state)
      ST_ACC_V: begin
        div_start = !run;
        div_x     = DW'(acc_in[ax]) <<< FRAC_BITS;
        div_d     = DIV_IMU;
      end
      ST_ACC_P: begin
        div_start = !run;
        div_x     = DW'(vel[ax]);
        div_d     = DIV_POS;
      end
      ST_ACC_PULL: begin
        div_start = !run;
        div_x     = DW'(ssub(refp[ax], pos[ax]));
        div_d     = DIV_PULL;
      end
      ST_BARO: begin
        mul_start = !run;
        mul_a     = ssub(baro_raw, baro_filtered);
        mul_g     = baro_gain;
      end
      ST_FLOW_S: begin
        mul_start = !run;
        mul_a     = W'(flow_in[ax[0]]);
        mul_g     = flow_scale;
      end
      ST_FLOW_V: begin
        mul_start = !run;
        mul_a     = ssub(st_val, vel[ax]);
        mul_g     = flow_vel_gain;
      end
      ST_ALT_V: begin
        mul_start = !run;
        mul_a     = ssub(mul100(alt_step), vel[2]);
        mul_g     = alt_flow ? flow_alt_vel_gain : baro_alt_vel_gain;
      end
      ST_TICK: begin
        mul_start = !run && !m_tvalid;
        mul_a     = ssub(pos[ax], pbias[ax]);
        mul_g     = output_scale;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      run   <= 1'b0;
      ax    <= '0;
    end else begin
      state <= state_next;
      if (mul_start || div_start) run <= 1'b1;
      else if (mul_done || div_done) run <= 1'b0;
      if (s_acc) begin
        ax <= '0;
      end else if (div_done || (mul_done && state != ST_FLOW_S)) begin
        // flow loops back to the scale step for the Y axis
        if (state_next != state && !(state == ST_FLOW_V && ax == 2'd0)) ax <= '0;
        else ax <= ax + 2'd1;
      end
    end
  end

  // capture
  always_ff @(posedge clk) begin
    if (s_acc) begin
      acc_in[0]  <= s_tdata[15:0];
      acc_in[1]  <= s_tdata[31:16];
      acc_in[2]  <= s_tdata[47:32];
      flow_in[0] <= s_tdata[79:48];
      flow_in[1] <= s_tdata[111:80];
      dist_in    <= s_tdata[143:112];
      baro_in    <= s_tdata[175:144];
    end
  end

  // state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vel[i]   <= '0;
        pos[i]   <= '0;
        refp[i]  <= '0;
        pbias[i] <= '0;
        vbias[i] <= '0;
      end
      baro_filtered <= '0;
      alt_previous  <= '0;
      alt_step      <= '0;
      last_accel_z  <= '0;
      mode_now      <= '0;
      mode_seen     <= '0;
      alt_val       <= '0;
      alt_flow      <= 1'b0;
    end else begin
      if (s_acc) begin
        case (s_tuser)
          CMD_ACCEL: last_accel_z <= s_tdata[47:32];
          CMD_FLIGHT: begin
            if (s_tdata[178:176] == 3'd1 || s_tdata[178:176] == 3'd2 ||
                s_tdata[178:176] == 3'd3) begin
              for (int i = 0; i < 3; i++) begin
                pbias[i] <= pos[i];
                vbias[i] <= vel[i];
              end
            end
          end
          CMD_MODE: mode_now <= s_tdata[186:179];
          default: ;
        endcase
      end
      case (state)
        ST_ACC_V:    if (div_done) vel[ax] <= sadd(vel[ax], div_w);
        ST_ACC_P, ST_ACC_PULL: if (div_done) pos[ax] <= sadd(pos[ax], div_w);
        ST_BARO: begin
          if (mul_done) begin
            baro_filtered <= bf_new;
            alt_val       <= bf_new;
            alt_flow      <= 1'b0;
          end
        end
        ST_FLOW_S: begin
          if (mul_done) begin
            refp[ax] <= sadd(refp[ax], flow_st);
            st_val   <= flow_st;
          end
        end
        ST_FLOW_V: begin
          if (mul_done) begin
            vel[ax] <= sadd(vel[ax], mulq);
            if (ax == 2'd1) begin
              alt_val  <= flow_alt;
              alt_flow <= 1'b1;
            end
          end
        end
        ST_ALT_SET: begin
          alt_step     <= alt_step_new;
          alt_previous <= alt_val;
          refp[2]      <= sadd(refp[2], alt_step_new);
          mode_seen    <= alt_flow ? ALT_MODE_FLOW : ALT_MODE_BARO;
        end
        ST_ALT_V: if (mul_done) vel[2] <= sadd(vel[2], mulq);
        default: ;
      endcase
    end
  end

  // result register
  logic signed [W-1:0] out_pos [3];
  logic signed [W-1:0] out_vel [3];
  logic [31:0]         out_alt_rate, out_vert_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_TICK && mul_done && ax == 2'd2) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_TICK && mul_done) begin
      out_pos[ax] <= tick_p;
      out_vel[ax] <= tick_v;
      if (ax == 2'd2) begin
        out_alt_rate <= to_int32(mul100(alt_step));
        out_vert_vel <= to_int32(vel[2]);
      end
    end
  end

  assign m_tdata = OUT_W'({out_vert_vel, out_alt_rate, out_vel[2], out_vel[1], out_vel[0],
                           out_pos[2], out_pos[1], out_pos[0]});

`ifndef SYNTH
  a_one_unit: assert property (@(posedge clk) disable iff (rst) !(mul_busy && div_busy))
    else $error("multiplier and divider active together");
  a_ax_range: assert property (@(posedge clk) disable iff (rst) ax != 2'd3)
    else $error("axis index out of range");
  a_tick_free: assert property (@(posedge clk) disable iff (rst)
      (state == ST_TICK && mul_done) |-> !m_tvalid)
    else $error("tick result overwrote a pending transfer");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
      (state == ST_IDLE) |-> !run)
    else $error("unit run flag left set in idle");
`endif

endmodule
`default_nettype wire

/* hw/rtl/navpf_mul_serial.sv */
// Bit-serial signed by unsigned 16-bit multiplier, one gain bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module navpf_mul_serial #(
  parameter int AW = navpf_pkg::STATE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [AW-1:0]                  a,
  input  wire logic [navpf_pkg::GAIN_W-1:0]          g,
  output logic                                       done,
  output logic                                       busy,
  output logic signed [AW+navpf_pkg::GAIN_W-1:0]     prod
);
  import navpf_pkg::*;

  localparam int PW = AW + GAIN_W;
  localparam int CW = $clog2(GAIN_W + 1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] a_r;
  logic [GAIN_W-1:0]    g_r;
  logic [CW-1:0]        cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(GAIN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= PW'(a);
      g_r <= g;
    end else if (busy) begin
      acc <= (acc <<< 1) + (g_r[GAIN_W-1] ? a_r : '0);
      g_r <= {g_r[GAIN_W-2:0], 1'b0};
    end
  end

  assign prod = acc;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("multiplier done without run");
  a_cnt_zero: assert property (@(posedge clk) disable iff (rst) !busy |-> cnt == '0)
    else $error("multiplier count left over");
`endif

endmodule
`default_nettype wire

/* hw/rtl/navpf_div_serial.sv */
// Restoring floor divider by a small constant, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module navpf_div_serial #(
  parameter int DW = navpf_pkg::STATE_WIDTH_DEF + navpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [DW-1:0]          x,
  input  wire logic [navpf_pkg::DIV_W-1:0]   d,
  output logic                               done,
  output logic                               busy,
  output logic signed [DW:0]                 q
);
  import navpf_pkg::*;

  localparam int MW = DW + 1;
  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0]    mag;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] d_r;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic [DIV_W:0]   cat;
  logic             ge;
  logic signed [MW-1:0] xe;

  assign xe  = MW'(x);
  assign cat = {rem, mag[MW-1]};
  assign ge  = cat >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= x[DW-1];
      d_r <= d;
      rem <= '0;
      mag <= x[DW-1] ? (MW'(-xe) + MW'(d) - MW'(1)) : MW'(xe);
    end else if (busy) begin
      rem <= ge ? DIV_W'(cat - {1'b0, d_r}) : DIV_W'(cat);
      mag <= {mag[MW-2:0], ge};
    end
  end

  assign q = neg ? $signed(MW'(-mag)) : $signed(mag);

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) busy |-> rem < d_r)
    else $error("divider remainder out of range");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without run");
`endif

endmodule
`default_nettype wire

/* bench/nav_position_fusion_checker.sv */
// Checker: watches all channels of the position fusion block, predicts and compares results
`timescale 1ns / 1ps
module nav_position_fusion_checker
  import navpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [351:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           errors,
  output int           pending
);

  localparam longint HI = (longint'(1) <<< 47) - 1;
  localparam longint LO = -HI - 1;

  typedef struct {
    logic signed [47:0] pos[3];
    logic signed [47:0] vel[3];
    logic signed [31:0] alt_rate;
    logic signed [31:0] vert_vel;
  } nav_out_t;

  nav_out_t results_due[$];

  logic [15:0] flow_scale, flow_vel_gain, flow_alt_gain, baro_alt_gain;
  logic [15:0] baro_fast, baro_slow, accel_thr, out_scale;
  longint vel[3], pos[3], ref_pos[3], pos_bias[3], vel_bias[3];
  longint baro_filt, alt_prev, alt_step;
  longint last_az;
  logic [7:0] mode_now, mode_seen;

  function automatic longint clampw(longint v);
    if (v > HI) return HI;
    if (v < LO) return LO;
    return v;
  endfunction

  function automatic longint sadd(longint a, longint b);
    return clampw(a + b);
  endfunction

  function automatic longint ssub(longint a, longint b);
    return clampw(a - b);
  endfunction

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint mulg(longint a, logic [15:0] g);
    return clampw((a * longint'({48'd0, g})) >>> 16);
  endfunction

  function automatic longint times100(longint a);
    if (a > HI / 100) return HI;
    if (a < LO / 100) return LO;
    return a * 100;
  endfunction

  function automatic logic [31:0] to_int32(longint v);
    longint q;
    q = v / 65536;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic alt_update(longint a, logic [7:0] m, logic [15:0] g);
    if (mode_seen != m) alt_prev = a;
    alt_step = ssub(a, alt_prev);
    alt_prev = a;
    vel[2] = sadd(vel[2], mulg(ssub(times100(alt_step), vel[2]), g));
    ref_pos[2] = sadd(ref_pos[2], alt_step);
    mode_seen = m;
  endtask

  task automatic clear_state();
    flow_scale = 655; flow_vel_gain = 655; flow_alt_gain = 655; baro_alt_gain = 328;
    baro_fast = 3277; baro_slow = 328; accel_thr = 300; out_scale = 13107;
    for (int i = 0; i < 3; i++) begin
      vel[i] = 0; pos[i] = 0; ref_pos[i] = 0; pos_bias[i] = 0; vel_bias[i] = 0;
    end
    baro_filt = 0; alt_prev = 0; alt_step = 0; last_az = 0;
    mode_now = ALT_MODE_BARO; mode_seen = ALT_MODE_BARO;
    results_due.delete();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      REG_FLOW_SCALE:    flow_scale = v;
      REG_FLOW_VEL_GAIN: flow_vel_gain = v;
      REG_FLOW_ALT_GAIN: flow_alt_gain = v;
      REG_BARO_ALT_GAIN: baro_alt_gain = v;
      REG_BARO_FAST:     baro_fast = v;
      REG_BARO_SLOW:     baro_slow = v;
      REG_ACCEL_THR:     accel_thr = v;
      default:           out_scale = v;
    endcase
  endtask

  task automatic apply_event(logic [2:0] cmd, logic [191:0] d);
    longint a[3], st[2], raw, p, v, az;
    nav_out_t r;
    logic [15:0] g;
    case (cmd)
      CMD_ACCEL: begin
        a[0] = longint'($signed(d[15:0]));
        a[1] = longint'($signed(d[31:16]));
        a[2] = longint'($signed(d[47:32]));
        last_az = a[2];
        for (int i = 0; i < 3; i++) vel[i] = sadd(vel[i], fdiv(a[i] * 65536, 4000));
        for (int i = 0; i < 2; i++) pos[i] = sadd(pos[i], fdiv(vel[i], 3200));
        for (int i = 0; i < 3; i++)
          pos[i] = sadd(pos[i], fdiv(ssub(ref_pos[i], pos[i]), 200));
      end
      CMD_BARO: begin
        raw = longint'($signed(d[175:144]));
        az = last_az < 0 ? -last_az : last_az;
        g = (az > longint'({48'd0, accel_thr})) ? baro_fast : baro_slow;
        baro_filt = sadd(baro_filt, mulg(ssub(raw, baro_filt), g));
        if (mode_now == ALT_MODE_BARO) alt_update(baro_filt, ALT_MODE_BARO, baro_alt_gain);
      end
      CMD_FLOW: begin
        st[0] = clampw(longint'($signed(d[79:48])) * longint'({48'd0, flow_scale}));
        st[1] = clampw(longint'($signed(d[111:80])) * longint'({48'd0, flow_scale}));
        for (int i = 0; i < 2; i++) begin
          ref_pos[i] = sadd(ref_pos[i], st[i]);
          vel[i] = sadd(vel[i], mulg(ssub(st[i], vel[i]), flow_vel_gain));
        end
        if (mode_now == ALT_MODE_FLOW)
          alt_update(clampw(longint'($signed(d[143:112])) * 65536), ALT_MODE_FLOW,
                     flow_alt_gain);
      end
      CMD_TICK: begin
        for (int i = 0; i < 3; i++) begin
          p = mulg(ssub(pos[i], pos_bias[i]), out_scale);
          v = ssub(vel[i], vel_bias[i]);
          if (i < 2) begin
            p = ssub(0, p);
            v = ssub(0, v);
          end
          r.pos[i] = p[47:0];
          r.vel[i] = v[47:0];
        end
        r.alt_rate = to_int32(times100(alt_step));
        r.vert_vel = to_int32(vel[2]);
        results_due.push_back(r);
      end
      CMD_FLIGHT: begin
        if (d[178:176] >= 3'd1 && d[178:176] <= 3'd3)
          for (int i = 0; i < 3; i++) begin
            pos_bias[i] = pos[i];
            vel_bias[i] = vel[i];
          end
      end
      CMD_MODE: mode_now = d[186:179];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, longint e, longint g);
    if (e != g) begin
      $error("%s expected %0d actual %0d", name, e, g);
      errors++;
    end
  endtask

  task automatic check_result(logic [351:0] t);
    nav_out_t e;
    string nm[6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
    if (results_due.size() == 0) begin
      $error("result transfer with no result expected");
      errors++;
      return;
    end
    e = results_due.pop_front();
    for (int i = 0; i < 3; i++) begin
      check_field(nm[i], e.pos[i], $signed(t[48*i +: 48]));
      check_field(nm[3+i], e.vel[i], $signed(t[144+48*i +: 48]));
    end
    check_field("alt_rate_int", e.alt_rate, $signed(t[319:288]));
    check_field("vert_vel_int", e.vert_vel, $signed(t[351:320]));
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[4:2], pwdata[15:0]);
      if (s_tvalid && s_tready) apply_event(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
    pending <= results_due.size();
  end

endmodule

/* bench/nav_position_fusion_test.sv */
// Testbench top: drives events and register writes into the position fusion block
`timescale 1ns / 1ps
module nav_position_fusion_test;
  import navpf_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [351:0] m_tdata;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           errors, pending;
  bit           burst = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  nav_position_fusion i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  nav_position_fusion_checker i_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending
  );

  // sensor event: tdata fields from bit 0 up
  function automatic logic [191:0] pack_event(logic [15:0] ax, logic [15:0] ay,
      logic [15:0] az, logic [31:0] dx, logic [31:0] dy, logic [31:0] fdist,
      logic [31:0] baro, logic [2:0] fs, logic [7:0] mode);
    return {5'd0, mode, fs, baro, fdist, dy, dx, az, ay, ax};
  endfunction

  task automatic send_event(logic [2:0] cmd, logic [191:0] d);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] v[8]);
    for (int i = 0; i < 8; i++) reg_write(i[2:0], v[i]);
  endtask

  function automatic logic [15:0] rnd_accel();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 1200)) - 600);
  endfunction

  function automatic logic [31:0] rnd_wide(int span);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_event();
    int pick;
    logic [2:0] cmd;
    logic [7:0] mode;
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = CMD_ACCEL;
    else if (pick < 50) cmd = CMD_BARO;
    else if (pick < 65) cmd = CMD_FLOW;
    else if (pick < 85) cmd = CMD_TICK;
    else if (pick < 91) cmd = CMD_FLIGHT;
    else if (pick < 97) cmd = CMD_MODE;
    else cmd = 3'($urandom_range(6, 7));
    mode = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    send_event(cmd, pack_event(rnd_accel(), rnd_accel(), rnd_accel(),
        rnd_wide(3000), rnd_wide(3000), rnd_wide(400),
        rnd_wide(500 * 65536), 3'($urandom), mode));
  endtask

  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    forever begin
      int gap;
      gap = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    logic [15:0] cfg[8];
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default gains
    send_event(CMD_TICK, '0);
    send_event(CMD_ACCEL, pack_event(16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0, 0));
    send_event(CMD_ACCEL, pack_event(16'h8000, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0, 0));
    send_event(CMD_BARO, pack_event(0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0));
    send_event(CMD_BARO, pack_event(0, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
    send_event(CMD_TICK, '0);
    send_event(CMD_FLOW, pack_event(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
        32'h7fff_ffff, 0, 0, 0));
    send_event(CMD_MODE, pack_event(0, 0, 0, 0, 0, 0, 0, 0, ALT_MODE_FLOW));
    send_event(CMD_FLOW, pack_event(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff,
        32'h8000_0000, 0, 0, 0));
    send_event(CMD_FLOW, pack_event(0, 0, 0, 100, -100, 25, 0, 0, 0));
    send_event(CMD_TICK, '0);
    for (int f = 0; f < 8; f++)
      send_event(CMD_FLIGHT, pack_event(0, 0, 0, 0, 0, 0, 0, f[2:0], 0));
    send_event(CMD_MODE, pack_event(0, 0, 0, 0, 0, 0, 0, 0, ALT_MODE_BARO));
    send_event(CMD_BARO, pack_event(0, 0, 0, 0, 0, 0, 32'h0010_0000, 0, 0));
    send_event(CMD_MODE, pack_event(0, 0, 0, 0, 0, 0, 0, 0, 8'hff));
    send_event(CMD_BARO, pack_event(0, 0, 0, 0, 0, 0, 32'h0020_0000, 0, 0));
    send_event(3'd6, '1);
    send_event(3'd7, '1);
    send_event(CMD_TICK, '0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      for (int i = 0; i < 8; i++) begin
        case (phase)
          0: cfg[i] = 16'd0;
          1: cfg[i] = (i == 6) ? 16'd32768 : 16'hffff;
          2: cfg[i] = 16'($urandom_range(0, 65535));
          3: cfg[i] = 16'($urandom_range(100, 20000));
          default: cfg[i] = 16'($urandom_range(0, 4000));
        endcase
      end
      if (phase == 2) cfg[6] = 16'($urandom_range(0, 32768));
      set_all(cfg);
      for (int n = 0; n < 305; n++) begin
        if ($urandom_range(0, 39) == 0) burst = !burst;
        if (n == 150) begin
          s_tvalid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_event();
      end
      burst = 0;
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
